>>> hdl/pkf_pkg.sv
// Shared types and constants for the palette keyframe fader.
// Holds the scheme colour table, colour word packing and request/result codes.
// No dependencies.
package pkf_pkg;

    // Request opcodes (s_axis_tuser)
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SELECT = 2'd1;
    localparam logic [1:0] OP_CYCLE  = 2'd2;
    localparam logic [1:0] OP_INIT   = 2'd3;

    // Result kinds (m_axis_tuser)
    localparam logic [1:0] KIND_PAIR = 2'd0;
    localparam logic [1:0] KIND_MTN  = 2'd1;
    localparam logic [1:0] KIND_SKY  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SKY_UP = 1'b0;
    localparam logic CFG_HOLD   = 1'b1;

    localparam int unsigned COLOR_W    = 12;
    localparam int unsigned IN_TDATA_W = 16;
    localparam int unsigned OUT_TDATA_W = 48;
    localparam int unsigned TABLE_COLS = 8;   // checker pair plus six mountain colours

    localparam logic [23:0] SCHEME0_RGB [TABLE_COLS] = '{
        24'h6098D8, 24'h204090, 24'h005800, 24'h00A800,
        24'h28E028, 24'h204090, 24'h009000, 24'h00D000
    };
    localparam logic [23:0] SCHEME1_RGB [TABLE_COLS] = '{
        24'hE8D0A0, 24'hA88048, 24'h604018, 24'hA87830,
        24'hD8B868, 24'h806840, 24'h906828, 24'hC09848
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] light;
        logic [11:0] dark;
        logic [2:0]  slot;
        logic [11:0] color;
        logic [7:0]  sky;
        logic        last;
    } t_result;

    // Top three bits of each 8-bit channel: red at bit 1, green at 5, blue at 9
    function automatic logic [COLOR_W-1:0] rgb_to_word(input logic [23:0] rgb);
        return {rgb[7:5], 1'b0, rgb[15:13], 1'b0, rgb[23:21], 1'b0};
    endfunction

    // Target colour of an entry; entries past the table take zero
    function automatic logic [COLOR_W-1:0] scheme_color(input logic scheme,
                                                        input logic [3:0] idx);
        logic [COLOR_W-1:0] word;
        word = '0;
        if (idx < 4'(TABLE_COLS)) begin
            word = scheme ? rgb_to_word(SCHEME1_RGB[idx[2:0]])
                          : rgb_to_word(SCHEME0_RGB[idx[2:0]]);
        end
        return word;
    endfunction

endpackage

>>> hdl/palette_keyframe_fader.sv
// Palette keyframe fader: linear palette fade between constant colour schemes.
// Depends on pkf_pkg (colour table, codes, result type).
//
// Operation: one request at a time. A select or cycle request registers its sky
// result once the output is free, then builds the keyframe store colour by colour,
// one entry a cycle per keyframe after a read and a load; the keyframe memory's
// single write port sets that rate. A tick that applies a keyframe copies each
// colour in turn, emits the checker pair, then emits each mountain colour if any
// changed; a holding tick stays idle, and init emits the scheme-zero pair, sky
// and mountains. Reset: synchronous, active low; control state cleared, current
// colours read as scheme zero, keyframe memory left unwritten.
module palette_keyframe_fader #(
    parameter int KEYFRAMES       = 6,
    parameter int MOUNTAIN_COLORS = 6,
    parameter int SCHEME_COUNT    = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pkf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [15:0] scheme_select
    input  logic [1:0]                        s_axis_tuser,  // [1:0] opcode
    // result channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [11:0] light_color, [23:12] dark_color, [26:24] slot, [38:27] color,
    // [46:39] sky_offset, [47] zero
    output logic [pkf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [1:0]                        m_axis_tuser,  // [1:0] kind
    output logic                              m_axis_tlast,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [7:0]                        i_cfg_data
);
    import pkf_pkg::*;

    localparam int NCOL   = 2 + MOUNTAIN_COLORS;
    localparam int IW     = $clog2(NCOL);
    localparam int KDEPTH = KEYFRAMES * NCOL;
    localparam int KDW    = $clog2(KDEPTH);
    localparam int KW     = (KEYFRAMES > 1) ? $clog2(KEYFRAMES) : 1;
    // accumulated |delta| * (k+1) never exceeds 7 * KEYFRAMES
    localparam int AW     = $clog2(7 * KEYFRAMES + 1);
    // floor(m / KEYFRAMES) == (m * RECIP) >> SH, exact for m below 2^7
    localparam int SH     = 16;
    localparam logic [SH:0] RECIP = (SH+1)'(((1 << SH) + KEYFRAMES - 1) / KEYFRAMES);
    localparam int PW     = AW + SH + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SKY, S_B_RD, S_B_LD, S_B_RUN,
        S_T_RD, S_T_EV, S_T_PAIR, S_M_RD, S_M_OUT,
        S_I_PAIR, S_I_SKY, S_I_MTN
    } t_state;

    t_state            r_state;

    // configuration
    logic [7:0]        r_sky_up;
    logic [7:0]        r_hold_cfg;

    // fade control
    logic              r_scheme;
    logic              r_fade;
    logic [KW-1:0]     r_kf;
    logic [KDW-1:0]    r_kf_base;   // r_kf * NCOL, kept as a running sum
    logic [7:0]        r_hold_left;

    // sequencing
    logic [IW-1:0]     r_idx;
    logic [KW-1:0]     r_k;
    logic [KDW-1:0]    r_wr_addr;
    logic              r_changed;
    logic [COLOR_W-1:0] r_light;
    logic [COLOR_W-1:0] r_dark;

    // per-channel interpolation state
    logic [2:0]        r_a   [3];
    logic [2:0]        r_mag [3];
    logic              r_neg [3];
    logic [AW-1:0]     r_acc [3];

    // memories: current colours (with valid bits) and keyframe store
    logic [COLOR_W-1:0] r_cur_mem [NCOL];
    logic [NCOL-1:0]    r_cur_vld;
    logic [COLOR_W-1:0] r_cur_q;
    logic               r_cur_vq;
    logic [IW-1:0]      r_cur_aq;
    logic [COLOR_W-1:0] r_kf_mem [KDEPTH];
    logic [COLOR_W-1:0] r_kf_q;

    t_result           r_out;
    logic              r_out_valid;

    logic              out_free;
    logic              out_load;
    logic              accept;
    logic [KDW-1:0]    kf_rd_addr;
    logic [COLOR_W-1:0] cur_rd;
    logic [COLOR_W-1:0] tgt;
    logic [2:0]        ch_a   [3];
    logic [2:0]        ch_b   [3];
    logic [2:0]        ch_mag [3];
    logic              ch_neg [3];
    logic [AW-1:0]     n_acc  [3];
    logic [PW-1:0]     prod   [3];
    logic [2:0]        quo    [3];
    logic [2:0]        ch_v   [3];
    logic [COLOR_W-1:0] lerp_word;
    logic              idx_last;
    logic              k_last;
    logic              kf_last;

    function automatic t_result make_result(input logic [1:0] kind,
                                            input logic [COLOR_W-1:0] light,
                                            input logic [COLOR_W-1:0] dark,
                                            input logic [2:0] slot,
                                            input logic [COLOR_W-1:0] color,
                                            input logic [7:0] sky,
                                            input logic last);
        t_result res;
        res.kind  = kind;
        res.light = light;
        res.dark  = dark;
        res.slot  = slot;
        res.color = color;
        res.sky   = sky;
        res.last  = last;
        return res;
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    // a result register load happens in every emitting state once the slot is free
    assign out_load      = out_free && ((r_state == S_SKY)    || (r_state == S_T_PAIR) ||
                                        (r_state == S_M_OUT)  || (r_state == S_I_PAIR) ||
                                        (r_state == S_I_SKY)  || (r_state == S_I_MTN));

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {1'b0, r_out.sky, r_out.color, r_out.slot, r_out.dark,
                            r_out.light};

    assign kf_rd_addr = r_kf_base + KDW'(r_idx);
    assign idx_last   = (r_idx == IW'(NCOL - 1));
    assign k_last     = (r_k == KW'(KEYFRAMES - 1));
    assign kf_last    = (r_kf == KW'(KEYFRAMES - 1));

    // An entry never written since reset or init reads as its scheme-zero colour
    assign cur_rd = r_cur_vq ? r_cur_q : scheme_color(1'b0, 4'(r_cur_aq));
    assign tgt    = scheme_color(r_scheme, 4'(r_idx));

    // Per-channel interpolation: set-up from the current/target pair, then one
    // keyframe a cycle by accumulating |delta| and dividing by reciprocal multiply.
    always_comb begin
        lerp_word = '0;
        for (int c = 0; c < 3; c++) begin
            ch_a[c]   = cur_rd[1 + 4*c +: 3];
            ch_b[c]   = tgt[1 + 4*c +: 3];
            ch_neg[c] = (ch_a[c] > ch_b[c]);
            ch_mag[c] = ch_neg[c] ? (ch_a[c] - ch_b[c]) : (ch_b[c] - ch_a[c]);
            n_acc[c]  = r_acc[c] + AW'(r_mag[c]);
            prod[c]   = PW'(n_acc[c]) * PW'(RECIP);
            quo[c]    = 3'(prod[c] >> SH);
            ch_v[c]   = r_neg[c] ? (r_a[c] - quo[c]) : (r_a[c] + quo[c]);
            lerp_word[1 + 4*c +: 3] = ch_v[c];
        end
    end

    // Memories: registered reads, one write port each
    always_ff @(posedge i_clk) begin
        r_cur_q  <= r_cur_mem[r_idx];
        r_cur_vq <= r_cur_vld[r_idx];
        r_cur_aq <= r_idx;
        r_kf_q   <= r_kf_mem[kf_rd_addr];
        if (r_state == S_T_EV) begin
            r_cur_mem[r_idx] <= r_kf_q;
        end
        if (r_state == S_B_RUN) begin
            r_kf_mem[r_wr_addr] <= lerp_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sky_up    <= 8'd32;
            r_hold_cfg  <= 8'd6;
            r_scheme    <= 1'b0;
            r_fade      <= 1'b0;
            r_kf        <= '0;
            r_kf_base   <= '0;
            r_hold_left <= '0;
            r_idx       <= '0;
            r_k         <= '0;
            r_changed   <= 1'b0;
            r_cur_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SKY_UP: r_sky_up   <= i_cfg_data;
                    CFG_HOLD:   r_hold_cfg <= i_cfg_data;
                    default:    ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (s_axis_tuser)
                            OP_TICK: begin
                                if (r_fade) begin
                                    if (r_hold_left != 8'd0) begin
                                        r_hold_left <= r_hold_left - 8'd1;
                                    end else begin
                                        r_idx     <= '0;
                                        r_changed <= 1'b0;
                                        r_state   <= S_T_RD;
                                    end
                                end
                            end
                            OP_SELECT, OP_CYCLE: begin
                                if (SCHEME_COUNT == 1) begin
                                    r_scheme <= 1'b0;
                                end else if (s_axis_tuser == OP_SELECT) begin
                                    r_scheme <= s_axis_tdata[0];
                                end else begin
                                    r_scheme <= ~r_scheme;
                                end
                                r_fade      <= 1'b1;
                                r_kf        <= '0;
                                r_kf_base   <= '0;
                                r_hold_left <= '0;
                                r_state     <= S_SKY;
                            end
                            OP_INIT: begin
                                r_scheme    <= 1'b0;
                                r_cur_vld   <= '0;
                                r_fade      <= 1'b0;
                                r_kf        <= '0;
                                r_kf_base   <= '0;
                                r_hold_left <= '0;
                                r_state     <= S_I_PAIR;
                            end
                            default: ;
                        endcase
                    end
                end

                // select / cycle: sky offset, then rebuild the keyframe store
                S_SKY: begin
                    if (out_free) begin
                        r_out <= make_result(KIND_SKY, '0, '0, '0, '0,
                                             r_scheme ? r_sky_up : 8'd0, 1'b1);
                        r_idx   <= '0;
                        r_state <= S_B_RD;
                    end
                end
                S_B_RD: begin
                    r_state <= S_B_LD;
                end
                S_B_LD: begin
                    for (int c = 0; c < 3; c++) begin
                        r_a[c]   <= ch_a[c];
                        r_mag[c] <= ch_mag[c];
                        r_neg[c] <= ch_neg[c];
                        r_acc[c] <= '0;
                    end
                    r_k       <= '0;
                    r_wr_addr <= KDW'(r_idx);
                    r_state   <= S_B_RUN;
                end
                S_B_RUN: begin
                    for (int c = 0; c < 3; c++) begin
                        r_acc[c] <= n_acc[c];
                    end
                    r_k       <= r_k + KW'(1);
                    r_wr_addr <= r_wr_addr + KDW'(NCOL);
                    if (k_last) begin
                        if (idx_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_B_RD;
                        end
                    end
                end

                // tick: copy keyframe into current colours, noting mountain changes, then emit results
                S_T_RD: begin
                    r_state <= S_T_EV;
                end
                S_T_EV: begin
                    r_cur_vld[r_idx] <= 1'b1;
                    if (r_idx == IW'(0)) begin
                        r_light <= r_kf_q;
                    end
                    if (r_idx == IW'(1)) begin
                        r_dark <= r_kf_q;
                    end
                    if (r_idx >= IW'(2) && cur_rd != r_kf_q) begin
                        r_changed <= 1'b1;
                    end
                    if (idx_last) begin
                        r_state <= S_T_PAIR;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_T_RD;
                    end
                end
                S_T_PAIR: begin
                    if (out_free) begin
                        r_out <= make_result(KIND_PAIR, r_light, r_dark, '0, '0, '0,
                                             !r_changed);
                        r_hold_left <= (r_hold_cfg != 8'd0) ? r_hold_cfg - 8'd1 : 8'd0;
                        if (kf_last) begin
                            r_fade    <= 1'b0;
                            r_kf      <= '0;
                            r_kf_base <= '0;
                        end else begin
                            r_kf      <= r_kf + KW'(1);
                            r_kf_base <= r_kf_base + KDW'(NCOL);
                        end
                        if (r_changed) begin
                            r_idx   <= IW'(2);
                            r_state <= S_M_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_M_RD: begin
                    r_state <= S_M_OUT;
                end
                S_M_OUT: begin
                    if (out_free) begin
                        r_out <= make_result(KIND_MTN, '0, '0, 3'(r_idx - IW'(2)),
                                             cur_rd, '0, idx_last);
                        if (idx_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_M_RD;
                        end
                    end
                end

                // init: scheme zero straight from the table
                S_I_PAIR: begin
                    if (out_free) begin
                        r_out <= make_result(KIND_PAIR, scheme_color(1'b0, 4'd0),
                                             scheme_color(1'b0, 4'd1), '0, '0, '0, 1'b0);
                        r_state <= S_I_SKY;
                    end
                end
                S_I_SKY: begin
                    if (out_free) begin
                        r_out   <= make_result(KIND_SKY, '0, '0, '0, '0, '0, 1'b0);
                        r_idx   <= IW'(2);
                        r_state <= S_I_MTN;
                    end
                end
                S_I_MTN: begin
                    if (out_free) begin
                        r_out <= make_result(KIND_MTN, '0, '0, 3'(r_idx - IW'(2)),
                                             scheme_color(1'b0, 4'(r_idx)), '0, idx_last);
                        if (idx_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for palette_keyframe_fader: drives requests on the stream
// input, predicts every result in a scoreboard class and checks each field on output.
// Depends on pkf_pkg for the opcodes, result kinds, register indexes and result type.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pkf_pkg::*;

    // Scoreboard: keeps its own copy of the palette, keyframes and counters, and queues
    // the results each accepted request must cause, in order.
    class palette_fade_board;
        logic [23:0] rgb_by_scheme [2][8];
        logic [11:0] shown [8];          // checker light, checker dark, six mountains
        logic [11:0] frames [6][8];      // keyframe store, one row per keyframe
        int unsigned frame_no;
        int unsigned hold_left;
        bit          fading;
        bit          scheme;
        logic [7:0]  sky_up;
        logic [7:0]  hold_cfg;
        t_result     expected_colours [$];
        int unsigned failures;

        function new();
            rgb_by_scheme = '{
                '{24'h6098D8, 24'h204090, 24'h005800, 24'h00A800,
                  24'h28E028, 24'h204090, 24'h009000, 24'h00D000},
                '{24'hE8D0A0, 24'hA88048, 24'h604018, 24'hA87830,
                  24'hD8B868, 24'h806840, 24'h906828, 24'hC09848}
            };
            sky_up    = 8'd32;
            hold_cfg  = 8'd6;
            frame_no  = 0;
            hold_left = 0;
            fading    = 1'b0;
            scheme    = 1'b0;
            failures  = 0;
            load_scheme_zero();
        endfunction

        // Keep the top three bits of each 8-bit channel: red at 1, green at 5, blue at 9
        function logic [11:0] target(bit s, int idx);
            logic [23:0] rgb;
            rgb = rgb_by_scheme[s][idx];
            return 12'(((rgb >> 20) & 24'hE) | ((rgb >> 8) & 24'hE0) | ((rgb << 4) & 24'hE00));
        endfunction

        // Per-channel step towards the target; integer division truncates toward zero
        function logic [11:0] blend(logic [11:0] src, logic [11:0] dst, int step);
            logic [11:0] mix;
            int          a;
            int          b;
            int          v;
            mix = '0;
            for (int sh = 1; sh <= 9; sh += 4) begin
                a = int'(src[sh +: 3]);
                b = int'(dst[sh +: 3]);
                v = a + ((b - a) * step) / 6;
                mix[sh +: 3] = v[2:0];
            end
            return mix;
        endfunction

        function void load_scheme_zero();
            for (int i = 0; i < 8; i++) shown[i] = target(1'b0, i);
        endfunction

        function void push(logic [1:0] k, logic [11:0] lt, logic [11:0] dk,
                           logic [2:0] sl, logic [11:0] col, logic [7:0] sky);
            t_result r;
            r.kind  = k;
            r.light = lt;
            r.dark  = dk;
            r.slot  = sl;
            r.color = col;
            r.sky   = sky;
            r.last  = 1'b0;
            expected_colours.push_back(r);
        endfunction

        function void push_mountains();
            for (int i = 0; i < 6; i++) push(KIND_MTN, '0, '0, 3'(i), shown[2 + i], '0);
        endfunction

        function void rebuild(bit s);
            scheme = s;
            push(KIND_SKY, '0, '0, '0, '0, s ? sky_up : 8'd0);
            for (int k = 0; k < 6; k++)
                for (int i = 0; i < 8; i++)
                    frames[k][i] = blend(shown[i], target(s, i), k + 1);
            frame_no  = 0;
            hold_left = 0;
            fading    = 1'b1;
        endfunction

        // Note an accepted request; return 0 when the block merely ignores it
        function bit note_request(logic [1:0] op, logic [15:0] sel);
            int unsigned kf;
            int unsigned queued;
            bit          changed;
            queued  = expected_colours.size();
            changed = 1'b0;
            case (op)
                OP_TICK: begin
                    if (!fading) return 1'b0;
                    if (hold_left > 0) begin
                        hold_left--;
                        return 1'b1;
                    end
                    kf = frame_no < 6 ? frame_no : 0;
                    shown[0] = frames[kf][0];
                    shown[1] = frames[kf][1];
                    push(KIND_PAIR, shown[0], shown[1], '0, '0, '0);
                    for (int i = 2; i < 8; i++) begin
                        if (shown[i] != frames[kf][i]) begin
                            shown[i] = frames[kf][i];
                            changed  = 1'b1;
                        end
                    end
                    if (changed) push_mountains();
                    // a hold of zero frames behaves as one
                    hold_left = hold_cfg != 0 ? hold_cfg - 1 : 0;
                    frame_no  = kf + 1;
                    if (frame_no >= 6) begin
                        fading   = 1'b0;
                        frame_no = frame_no & 7;
                    end
                end
                OP_SELECT: rebuild(sel[0]);
                OP_CYCLE:  rebuild(~scheme);
                default: begin
                    scheme = 1'b0;
                    load_scheme_zero();
                    push(KIND_PAIR, shown[0], shown[1], '0, '0, '0);
                    push(KIND_SKY, '0, '0, '0, '0, '0);
                    push_mountains();
                    frame_no  = 0;
                    hold_left = 0;
                    fading    = 1'b0;
                end
            endcase
            if (expected_colours.size() > queued)
                expected_colours[expected_colours.size() - 1].last = 1'b1;
            return 1'b1;
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [47:0] data, logic [1:0] kind, logic last);
            t_result want;
            if (expected_colours.size() == 0) begin
                $error("result with nothing expected: kind %0h data %0h", kind, data);
                failures++;
                return;
            end
            want = expected_colours.pop_front();
            compare("kind", want.kind, kind);
            compare("light_color", want.light, data[11:0]);
            compare("dark_color", want.dark, data[23:12]);
            compare("slot", want.slot, data[26:24]);
            compare("color", want.color, data[38:27]);
            compare("sky_offset", want.sky, data[46:39]);
            compare("pad", 1'b0, data[47]);
            compare("last", want.last, last);
        endfunction
    endclass

    // Register settings of the random phases: reset values, then extremes and a few
    // in between; a hold of zero is the special case that must act as one frame.
    localparam logic [7:0] PHASE_SKY  [6] = '{8'd32, 8'd0, 8'd255, 8'h5A, 8'hA5, 8'd1};
    localparam logic [7:0] PHASE_HOLD [6] = '{8'd6, 8'd1, 8'd255, 8'd0, 8'd2, 8'd3};
    localparam int         PHASE_ITEMS    = 62;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;         // [15:0] scheme_select
    logic [1:0]  s_axis_tuser  = OP_TICK;    // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [11:0] light_color, [23:12] dark_color, [26:24] slot, [38:27] color,
    // [46:39] sky_offset, [47] zero
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;               // [1:0] kind
    logic        m_axis_tlast;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = CFG_SKY_UP;
    logic [7:0]  i_cfg_data    = '0;

    palette_fade_board board = new();

    // Idle percentages of sender and receiver, set by the stimulus process only
    int tx_gap_pct  = 15;
    int rx_gap_pct  = 81;
    int random_done = 0;
    bit stall_toggle = 1'b0;   // flip to make the receiver hold off for a long stretch

    always #5 i_clk = ~i_clk;

    palette_keyframe_fader u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Result side: check what was accepted at this edge (values seen are those from
    // before the edge), then choose tready for the next cycle. A flip of stall_toggle
    // starts a long hold-off, counted here, so the block fills up and stalls its input.
    bit stall_seen = 1'b0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (stall_toggle != stall_seen) begin
            stall_seen = stall_toggle;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_gap_pct);
        end
    end

    // Offer one request, with random idle cycles first; return once it is accepted.
    // tvalid is left high so a following request goes out back to back.
    task automatic send_request(input logic [1:0] op, input logic [15:0] sel,
                                output bit acted);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= sel;
        do @(posedge i_clk); while (!s_axis_tready);
        acted = board.note_request(op, sel);
    endtask

    // Drop tvalid, wait for every expected result, then let a keyframe rebuild or a
    // holding tick finish before anything else touches the block.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.expected_colours.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] sky, input logic [7:0] hold);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SKY_UP;
        i_cfg_data  <= sky;
        @(posedge i_clk);
        i_cfg_index <= CFG_HOLD;
        i_cfg_data  <= hold;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.sky_up   = sky;
        board.hold_cfg = hold;
    endtask

    // Mostly well-formed fades: a select or cycle, then ticks to play the fade through,
    // capped at 45 (sometimes cut short so a new selection lands mid-fade). The rest is
    // init followed by a few ticks, and short bursts of any opcode.
    task automatic random_phase(input int quota);
        int          done;
        int          run;
        int          roll;
        bit          acted;
        int unsigned hold_eff;
        done = 0;
        while (done < quota) begin
            if (random_done + done < 143) begin
                tx_gap_pct = 15;
                rx_gap_pct = 81;
            end else if (random_done + done < 286) begin
                tx_gap_pct = 81;
                rx_gap_pct = 15;
            end else begin
                tx_gap_pct = 0;
                rx_gap_pct = 0;
            end
            roll = $urandom_range(99);
            if (roll < 75) begin
                send_request(roll < 40 ? OP_SELECT : OP_CYCLE, 16'($urandom), acted);
                done += acted;
                hold_eff = board.hold_cfg == 0 ? 1 : board.hold_cfg;
                run = 6 * hold_eff + $urandom_range(4);
                if (run > 45) run = 45;
                if ($urandom_range(3) == 0) run = $urandom_range(run, 1);
                repeat (run) begin
                    send_request(OP_TICK, 16'($urandom), acted);
                    done += acted;
                end
            end else if (roll < 85) begin
                send_request(OP_INIT, 16'($urandom), acted);
                done += acted;
                repeat ($urandom_range(3)) begin
                    send_request(OP_TICK, 16'($urandom), acted);
                    done += acted;
                end
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    send_request(2'($urandom), 16'($urandom), acted);
                    done += acted;
                end
            end
        end
        random_done += done;
    endtask

    initial begin
        bit acted;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: tick with no fade running, init, a selection of the scheme
        // already shown (checker pair only, mountains unchanged), then a full scheme
        // change with the six-frame hold between keyframes.
        send_request(OP_TICK, 16'hFFFF, acted);
        send_request(OP_INIT, 16'h0000, acted);
        send_request(OP_SELECT, 16'h0000, acted);
        send_request(OP_TICK, 16'h0000, acted);
        send_request(OP_SELECT, 16'hFFFF, acted);
        repeat (8) send_request(OP_TICK, 16'($urandom), acted);
        settle();

        // Widest sky offset, one frame per keyframe: fade back from a partly done fade,
        // tick past its end, cycle, break a fade with init, cycle from scheme zero.
        write_config(8'hFF, 8'd1);
        send_request(OP_SELECT, 16'h0002, acted);
        repeat (7) send_request(OP_TICK, 16'($urandom), acted);
        send_request(OP_CYCLE, 16'($urandom), acted);
        repeat (2) send_request(OP_TICK, 16'($urandom), acted);
        send_request(OP_INIT, 16'($urandom), acted);
        send_request(OP_CYCLE, 16'($urandom), acted);
        settle();

        for (int p = 0; p < 6; p++) begin
            write_config(PHASE_SKY[p], PHASE_HOLD[p]);
            // in the last phase, hold the result side off while requests keep coming
            if (p == 5) stall_toggle = ~stall_toggle;
            random_phase(PHASE_ITEMS);
            settle();
        end

        if (board.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
hdl/pkf_pkg.sv
hdl/palette_keyframe_fader.sv
tb/testbench.sv
